@@ src/rk4sd_pkg.sv @@
// shared types, constants and step sequence of the rk4 spring-damper stepper
package rk4sd_pkg;

   // number format and field widths
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int DT_W       = 17;
   localparam int COEF_W     = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int PROD_W     = DATA_W + COEF_W;
   localparam int Q_W        = PROD_W - FRAC_W;
   localparam int RECIP_W    = 30;
   localparam int DT6_PROD_W = DT_W + RECIP_W;
   localparam int STEP_W     = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING   = 2'd2;

   // reset values and the reciprocal of six in 0.32 form
   localparam logic [DT_W-1:0]    TIME_STEP_RST = 17'd6554;
   localparam logic [DT_W-1:0]    DT6_RST       = 17'd1092;
   localparam logic [COEF_W-1:0]  SPRING_RST    = 31'd131072;
   localparam logic [COEF_W-1:0]  DAMPING_RST   = 31'd131072;
   localparam logic [RECIP_W-1:0] RECIP_SIXTH   = 30'd715827883;

   localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // multiplier operand a: a signed state value
   typedef enum logic [2:0] {
      MA_POS,
      MA_VEL,
      MA_XS,
      MA_VS,
      MA_ACC,
      MA_SV,
      MA_SA
   } mul_a_type;

   // multiplier operand b: a nonnegative coefficient or step
   typedef enum logic [2:0] {
      MB_K,
      MB_C,
      MB_HDT,
      MB_DT,
      MB_DT6
   } mul_b_type;

   // destination of the saturating add that consumes the last product
   typedef enum logic [2:0] {
      AD_NONE,
      AD_T,
      AD_A,
      AD_XS,
      AD_VS,
      AD_POS,
      AD_VEL
   } add_dst_type;

   // weighted slope sums
   typedef enum logic [2:0] {
      AC_NONE,
      AC_SV_LOAD,
      AC_SA_LOAD,
      AC_SV_DBL,
      AC_SA_DBL,
      AC_SV_ADD,
      AC_SA_ADD
   } acc_type;

   typedef struct packed {
      logic        mul_en;
      mul_a_type   mul_a;
      mul_b_type   mul_b;
      add_dst_type add_dst;
      acc_type     acc;
   } ucode_type;

   // a row per cycle unless stalled: issue a product, fold the prior, sum slopes
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type u;
      u.mul_en  = 1'b1;
      u.mul_a   = MA_POS;
      u.mul_b   = MB_K;
      u.add_dst = AD_NONE;
      u.acc     = AC_NONE;
      case (step)
         5'd0: begin
            u.mul_a = MA_POS; u.mul_b = MB_K;   u.acc = AC_SV_LOAD;
         end
         5'd1: begin
            u.mul_a = MA_VEL; u.mul_b = MB_C;   u.add_dst = AD_T;
         end
         5'd2: begin
            u.mul_a = MA_VEL; u.mul_b = MB_HDT; u.add_dst = AD_A;
         end
         5'd3: begin
            u.mul_a = MA_ACC; u.mul_b = MB_HDT; u.add_dst = AD_XS; u.acc = AC_SA_LOAD;
         end
         5'd4: begin
            u.mul_a = MA_XS;  u.mul_b = MB_K;   u.add_dst = AD_VS;
         end
         5'd5: begin
            u.mul_a = MA_VS;  u.mul_b = MB_C;   u.add_dst = AD_T;  u.acc = AC_SV_DBL;
         end
         5'd6: begin
            u.mul_a = MA_VS;  u.mul_b = MB_HDT; u.add_dst = AD_A;
         end
         5'd7: begin
            u.mul_a = MA_ACC; u.mul_b = MB_HDT; u.add_dst = AD_XS; u.acc = AC_SA_DBL;
         end
         5'd8: begin
            u.mul_a = MA_XS;  u.mul_b = MB_K;   u.add_dst = AD_VS;
         end
         5'd9: begin
            u.mul_a = MA_VS;  u.mul_b = MB_C;   u.add_dst = AD_T;  u.acc = AC_SV_DBL;
         end
         5'd10: begin
            u.mul_a = MA_VS;  u.mul_b = MB_DT;  u.add_dst = AD_A;
         end
         5'd11: begin
            u.mul_a = MA_ACC; u.mul_b = MB_DT;  u.add_dst = AD_XS; u.acc = AC_SA_DBL;
         end
         5'd12: begin
            u.mul_a = MA_XS;  u.mul_b = MB_K;   u.add_dst = AD_VS;
         end
         5'd13: begin
            u.mul_a = MA_VS;  u.mul_b = MB_C;   u.add_dst = AD_T;  u.acc = AC_SV_ADD;
         end
         5'd14: begin
            u.mul_a = MA_SV;  u.mul_b = MB_DT6; u.add_dst = AD_A;
         end
         5'd15: begin
            u.mul_en = 1'b0;  u.add_dst = AD_POS; u.acc = AC_SA_ADD;
         end
         5'd16: begin
            u.mul_a = MA_SA;  u.mul_b = MB_DT6;
         end
         5'd17: begin
            u.mul_en = 1'b0;  u.add_dst = AD_VEL;
         end
         default: begin
            u.mul_en = 1'b0;
         end
      endcase
      return u;
   endfunction

endpackage

@@ src/rk4_spring_damper_step_top.sv @@
// rk4 spring-damper stepper: sequencer around one shared multiplier and saturating adders
//
//   beat     ports                              carries
//   req      req_valid/req_ready                force_req, signed Q16.16
//   rsp      rsp_valid/rsp_ready                position, velocity, overflow
//   csr      csr_write_en/csr_index/csr_wdata   time_step, spring_stiffness, damping_coeff
//
// a new item is accepted only in idle, after the previous one has run 18 sequencer steps
// issuing 16 32x31 products, each folded into a state value one step later. the step count
// is set by the single multiplier and the dependent chain of four slope evaluations.
// reset clears position, velocity and control and loads the register defaults.
// a result waits in the rsp register; the sequencer holds on its last step while it is not taken.
module rk4_spring_damper_step_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [rk4sd_pkg::DATA_W-1:0] req_force_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rk4sd_pkg::DATA_W-1:0] rsp_position,
   output logic signed [rk4sd_pkg::DATA_W-1:0] rsp_velocity,
   output logic                               rsp_overflow,
   input  logic                               csr_write_en,
   input  logic [rk4sd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rk4sd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DW = rk4sd_pkg::DATA_W;

   // exact 34-bit value clamped to the word range, flag in the top bit
   function automatic logic [DW:0] clamp_word(input logic signed [DW+1:0] s);
      logic signed [DW+1:0] hi_lim;
      logic signed [DW+1:0] lo_lim;
      hi_lim = {3'b000, {(DW-1){1'b1}}};
      lo_lim = {3'b111, {(DW-1){1'b0}}};
      if (s > hi_lim) begin
         clamp_word = {1'b1, hi_lim[DW-1:0]};
      end else if (s < lo_lim) begin
         clamp_word = {1'b1, lo_lim[DW-1:0]};
      end else begin
         clamp_word = {1'b0, s[DW-1:0]};
      end
   endfunction

   function automatic logic signed [DW+1:0] ext(input logic [DW-1:0] w);
      ext = {{2{w[DW-1]}}, w};
   endfunction

   // control state
   rk4sd_pkg::state_type           state_ff, state_in;
   logic [rk4sd_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           sat_ff, sat_in;
   logic                           run_adv;
   logic                           finish;
   logic                           accept;

   // configuration
   logic [rk4sd_pkg::DT_W-1:0]     time_step_ff, time_step_in;
   logic [rk4sd_pkg::DT_W-1:0]     dt6_ff, dt6_in;
   logic [rk4sd_pkg::COEF_W-1:0]   spring_ff, spring_in;
   logic [rk4sd_pkg::COEF_W-1:0]   damping_ff, damping_in;
   logic [rk4sd_pkg::DT6_PROD_W-1:0] dt6_prod;

   // datapath state
   rk4sd_pkg::word_type pos_ff, pos_in;
   rk4sd_pkg::word_type vel_ff, vel_in;
   rk4sd_pkg::word_type force_ff, force_in;
   rk4sd_pkg::word_type t_ff, t_in;
   rk4sd_pkg::word_type acc_ff, acc_in;
   rk4sd_pkg::word_type xs_ff, xs_in;
   rk4sd_pkg::word_type vs_ff, vs_in;
   rk4sd_pkg::word_type sv_ff, sv_in;
   rk4sd_pkg::word_type sa_ff, sa_in;
   logic [rk4sd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                         neg_ff, neg_in;

   // result register
   rk4sd_pkg::word_type rsp_position_ff, rsp_position_in;
   rk4sd_pkg::word_type rsp_velocity_ff, rsp_velocity_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   // datapath wires
   rk4sd_pkg::ucode_type          uc;
   logic [DW-1:0]                 mul_a_val;
   logic [DW-1:0]                 mag_a;
   logic [rk4sd_pkg::COEF_W-1:0]  mul_b_val;
   logic [rk4sd_pkg::Q_W-1:0]     quot;
   logic [rk4sd_pkg::Q_W-1:0]     lim;
   logic                          mul_sat;
   logic [DW-1:0]                 mul_mag;
   logic [DW-1:0]                 mul_res;
   logic [DW-1:0]                 add_base;
   logic                          add_sub;
   logic [DW:0]                   add_clamped;
   logic                          acc_is_sv;
   logic                          acc_dbl;
   logic                          acc_sum;
   logic [DW-1:0]                 acc_src;
   logic [DW-1:0]                 acc_base;
   logic [DW:0]                   dbl_clamped;
   logic [DW-1:0]                 acc_addend;
   logic [DW:0]                   accsum_clamped;

   assign uc     = rk4sd_pkg::ucode(step_ff);
   assign accept = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      run_adv   = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         rk4sd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = rk4sd_pkg::ST_RUN;
               step_in  = '0;
            end
         end
         rk4sd_pkg::ST_RUN: begin
            run_adv = !(step_ff == rk4sd_pkg::LAST_STEP && rsp_valid_ff && !rsp_ready);
            if (run_adv) begin
               if (step_ff == rk4sd_pkg::LAST_STEP) begin
                  finish   = 1'b1;
                  state_in = rk4sd_pkg::ST_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + rk4sd_pkg::STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = rk4sd_pkg::ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // multiplier operands, magnitude form
   always_comb begin
      case (uc.mul_a)
         rk4sd_pkg::MA_POS: mul_a_val = pos_ff;
         rk4sd_pkg::MA_VEL: mul_a_val = vel_ff;
         rk4sd_pkg::MA_XS:  mul_a_val = xs_ff;
         rk4sd_pkg::MA_VS:  mul_a_val = vs_ff;
         rk4sd_pkg::MA_ACC: mul_a_val = acc_ff;
         rk4sd_pkg::MA_SV:  mul_a_val = sv_ff;
         rk4sd_pkg::MA_SA:  mul_a_val = sa_ff;
         default:           mul_a_val = pos_ff;
      endcase
      case (uc.mul_b)
         rk4sd_pkg::MB_K:   mul_b_val = spring_ff;
         rk4sd_pkg::MB_C:   mul_b_val = damping_ff;
         rk4sd_pkg::MB_HDT: mul_b_val = {{(rk4sd_pkg::COEF_W-rk4sd_pkg::DT_W+1){1'b0}},
                                        time_step_ff[rk4sd_pkg::DT_W-1:1]};
         rk4sd_pkg::MB_DT:  mul_b_val = {{(rk4sd_pkg::COEF_W-rk4sd_pkg::DT_W){1'b0}},
                                        time_step_ff};
         rk4sd_pkg::MB_DT6: mul_b_val = {{(rk4sd_pkg::COEF_W-rk4sd_pkg::DT_W){1'b0}}, dt6_ff};
         default:           mul_b_val = spring_ff;
      endcase
      mag_a = mul_a_val[DW-1] ? (~mul_a_val + DW'(1)) : mul_a_val;
   end

   // scale the stored product, saturate, restore sign
   always_comb begin
      quot    = prod_ff[rk4sd_pkg::PROD_W-1:rk4sd_pkg::FRAC_W];
      lim     = {{(rk4sd_pkg::Q_W-DW){1'b0}}, neg_ff, {(DW-1){~neg_ff}}};
      mul_sat = quot > lim;
      mul_mag = mul_sat ? lim[DW-1:0] : quot[DW-1:0];
      mul_res = neg_ff ? (~mul_mag + DW'(1)) : mul_mag;
   end

   // saturating add of the scaled product into a state value
   always_comb begin
      add_base = pos_ff;
      add_sub  = 1'b0;
      case (uc.add_dst)
         rk4sd_pkg::AD_T: begin
            add_base = force_ff;
            add_sub  = 1'b1;
         end
         rk4sd_pkg::AD_A: begin
            add_base = t_ff;
            add_sub  = 1'b1;
         end
         rk4sd_pkg::AD_XS, rk4sd_pkg::AD_POS: begin
            add_base = pos_ff;
         end
         rk4sd_pkg::AD_VS, rk4sd_pkg::AD_VEL: begin
            add_base = vel_ff;
         end
         default: begin
            add_base = pos_ff;
         end
      endcase
      add_clamped = clamp_word(add_sub ? (ext(add_base) - ext(mul_res))
                                       : (ext(add_base) + ext(mul_res)));
   end

   // weighted slope sums, one term a step
   always_comb begin
      acc_is_sv = 1'b0;
      acc_dbl   = 1'b0;
      acc_sum   = 1'b0;
      case (uc.acc)
         rk4sd_pkg::AC_SV_DBL: begin
            acc_is_sv = 1'b1; acc_dbl = 1'b1; acc_sum = 1'b1;
         end
         rk4sd_pkg::AC_SA_DBL: begin
            acc_dbl = 1'b1; acc_sum = 1'b1;
         end
         rk4sd_pkg::AC_SV_ADD: begin
            acc_is_sv = 1'b1; acc_sum = 1'b1;
         end
         rk4sd_pkg::AC_SA_ADD: begin
            acc_sum = 1'b1;
         end
         default: begin
            acc_sum = 1'b0;
         end
      endcase
      acc_src        = acc_is_sv ? vs_ff : acc_ff;
      acc_base       = acc_is_sv ? sv_ff : sa_ff;
      dbl_clamped    = clamp_word(ext(acc_src) <<< 1);
      acc_addend     = acc_dbl ? dbl_clamped[DW-1:0] : acc_src;
      accsum_clamped = clamp_word(ext(acc_base) + ext(acc_addend));
   end

   // next values of configuration, datapath and result registers
   always_comb begin
      time_step_in    = time_step_ff;
      dt6_in          = dt6_ff;
      spring_in       = spring_ff;
      damping_in      = damping_ff;
      pos_in          = pos_ff;
      vel_in          = vel_ff;
      force_in        = force_ff;
      t_in            = t_ff;
      acc_in          = acc_ff;
      xs_in           = xs_ff;
      vs_in           = vs_ff;
      sv_in           = sv_ff;
      sa_in           = sa_ff;
      prod_in         = prod_ff;
      neg_in          = neg_ff;
      sat_in          = sat_ff;
      rsp_position_in = rsp_position_ff;
      rsp_velocity_in = rsp_velocity_ff;
      rsp_overflow_in = rsp_overflow_ff;

      // register writes; dt/6 by reciprocal at write time
      dt6_prod = rk4sd_pkg::DT6_PROD_W'(csr_wdata[rk4sd_pkg::DT_W-1:0])
               * rk4sd_pkg::DT6_PROD_W'(rk4sd_pkg::RECIP_SIXTH);
      if (csr_write_en) begin
         case (csr_index)
            rk4sd_pkg::CSR_TIME_STEP: begin
               time_step_in = csr_wdata[rk4sd_pkg::DT_W-1:0];
               dt6_in       = rk4sd_pkg::DT_W'(dt6_prod >> 32);
            end
            rk4sd_pkg::CSR_SPRING:  spring_in  = csr_wdata;
            rk4sd_pkg::CSR_DAMPING: damping_in = csr_wdata;
            default: begin
               spring_in = spring_ff;
            end
         endcase
      end

      if (accept) begin
         force_in = req_force_req;
         sat_in   = 1'b0;
      end

      if (state_ff == rk4sd_pkg::ST_RUN && run_adv) begin
         if (uc.mul_en) begin
            prod_in = rk4sd_pkg::PROD_W'(mag_a) * rk4sd_pkg::PROD_W'(mul_b_val);
            neg_in  = mul_a_val[DW-1];
         end
         case (uc.add_dst)
            rk4sd_pkg::AD_T:   t_in   = add_clamped[DW-1:0];
            rk4sd_pkg::AD_A:   acc_in = add_clamped[DW-1:0];
            rk4sd_pkg::AD_XS:  xs_in  = add_clamped[DW-1:0];
            rk4sd_pkg::AD_VS:  vs_in  = add_clamped[DW-1:0];
            rk4sd_pkg::AD_POS: pos_in = add_clamped[DW-1:0];
            rk4sd_pkg::AD_VEL: vel_in = add_clamped[DW-1:0];
            default: begin
               t_in = t_ff;
            end
         endcase
         case (uc.acc)
            rk4sd_pkg::AC_SV_LOAD: sv_in = vel_ff;
            rk4sd_pkg::AC_SA_LOAD: sa_in = acc_ff;
            rk4sd_pkg::AC_SV_DBL, rk4sd_pkg::AC_SV_ADD: sv_in = accsum_clamped[DW-1:0];
            rk4sd_pkg::AC_SA_DBL, rk4sd_pkg::AC_SA_ADD: sa_in = accsum_clamped[DW-1:0];
            default: begin
               sv_in = sv_ff;
            end
         endcase
         sat_in = sat_ff
                | ((uc.add_dst != rk4sd_pkg::AD_NONE) && (mul_sat || add_clamped[DW]))
                | (acc_sum && ((acc_dbl && dbl_clamped[DW]) || accsum_clamped[DW]));
         if (finish) begin
            rsp_position_in = pos_ff;
            rsp_velocity_in = add_clamped[DW-1:0];
            rsp_overflow_in = sat_in;
         end
      end
   end

   // result beat held until taken
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rk4sd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         time_step_ff <= rk4sd_pkg::TIME_STEP_RST;
         dt6_ff       <= rk4sd_pkg::DT6_RST;
         spring_ff    <= rk4sd_pkg::SPRING_RST;
         damping_ff   <= rk4sd_pkg::DAMPING_RST;
         pos_ff       <= '0;
         vel_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_ff       <= sat_in;
         time_step_ff <= time_step_in;
         dt6_ff       <= dt6_in;
         spring_ff    <= spring_in;
         damping_ff   <= damping_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      force_ff        <= force_in;
      t_ff            <= t_in;
      acc_ff          <= acc_in;
      xs_ff           <= xs_in;
      vs_ff           <= vs_in;
      sv_ff           <= sv_in;
      sa_ff           <= sa_in;
      prod_ff         <= prod_in;
      neg_ff          <= neg_in;
      rsp_position_ff <= rsp_position_in;
      rsp_velocity_ff <= rsp_velocity_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_velocity = rsp_velocity_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // accepted beat starts the sequence at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rk4sd_pkg::ST_RUN && step_ff == '0))
      else $error("sequence did not start after accepted beat");

   // a result appears only out of the last step
   a_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff == rk4sd_pkg::ST_RUN && step_ff == rk4sd_pkg::LAST_STEP))
      else $error("result raised outside the last step");

   // a waiting result holds the sequencer on its last step
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rk4sd_pkg::ST_RUN && step_ff == rk4sd_pkg::LAST_STEP
       && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == rk4sd_pkg::ST_RUN && step_ff == rk4sd_pkg::LAST_STEP && rsp_valid_ff))
      else $error("last step passed while result slot full");

   // step counter stays inside the sequence
   a_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rk4sd_pkg::ST_RUN) |-> (step_ff <= rk4sd_pkg::LAST_STEP))
      else $error("step counter beyond sequence");

   // position and velocity only move while a step runs
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rk4sd_pkg::ST_IDLE) |=> ($stable(pos_ff) && $stable(vel_ff)))
      else $error("state changed while idle");

endmodule

@@ verif/rk4_spring_damper_step_top_tb.sv @@
// self-checking testbench for the rk4 spring-damper stepper
`timescale 1ns / 1ps

module rk4_spring_damper_step_top_tb;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint unsigned NEG_LIMIT = 64'd2147483648;
   localparam longint SIXTH_Q32 = 64'sd715827883;
   localparam logic [rk4sd_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_PHASES = 14;

   typedef struct {
      rk4sd_pkg::word_type position;
      rk4sd_pkg::word_type velocity;
      logic                overflow;
   } step_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rk4sd_pkg::word_type req_force_req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rk4sd_pkg::word_type rsp_position;
   rk4sd_pkg::word_type rsp_velocity;
   logic rsp_overflow;
   logic csr_write_en = 1'b0;
   logic [rk4sd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rk4sd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state and its registers
   longint model_pos = 0;
   longint model_vel = 0;
   logic [rk4sd_pkg::DT_W-1:0] cfg_dt = rk4sd_pkg::TIME_STEP_RST;
   logic [rk4sd_pkg::COEF_W-1:0] cfg_k = rk4sd_pkg::SPRING_RST;
   logic [rk4sd_pkg::COEF_W-1:0] cfg_c = rk4sd_pkg::DAMPING_RST;
   bit step_sat;

   rk4sd_pkg::word_type force_q[$];
   step_result_type next_state_q[$];
   step_result_type predicted;
   int forces_queued = 0;
   int forces_taken = 0;
   int ticks_checked = 0;
   int mismatches = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int gap_left = 0;
   int stall_left = 0;
   logic req_fired = 1'b0;

   rk4_spring_damper_step_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_force_req(req_force_req),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_velocity (rsp_velocity),
      .rsp_overflow (rsp_overflow),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // saturating arithmetic on 32-bit signed q16.16 words
   function automatic longint sat_word(input longint r);
      if (r > WORD_MAX) begin
         step_sat = 1'b1;
         return WORD_MAX;
      end
      if (r < WORD_MIN) begin
         step_sat = 1'b1;
         return WORD_MIN;
      end
      return r;
   endfunction

   // product magnitude truncated toward zero, then saturated
   function automatic longint fx_mul(input longint a, input longint b);
      longint unsigned ma, mb, m;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb) >> rk4sd_pkg::FRAC_W;
      if ((a < 0) != (b < 0)) begin
         if (m > NEG_LIMIT) begin
            step_sat = 1'b1;
            return WORD_MIN;
         end
         return -longint'(m);
      end
      if (m > WORD_MAX) begin
         step_sat = 1'b1;
         return WORD_MAX;
      end
      return longint'(m);
   endfunction

   // a = (f - k*x) - c*v
   function automatic longint accel_of(input longint x, input longint v, input longint f);
      longint t, k, c;
      k = longint'(cfg_k);
      c = longint'(cfg_c);
      t = sat_word(f - fx_mul(k, x));
      return sat_word(t - fx_mul(c, v));
   endfunction

   // rk4 weights 1, 2, 2, 1 with saturation at every add
   function automatic longint slope_sum(input longint s1, input longint s2,
                                        input longint s3, input longint s4);
      longint s;
      s = sat_word(s1 + sat_word(s2 + s2));
      s = sat_word(s + sat_word(s3 + s3));
      return sat_word(s + s4);
   endfunction

   // one rk4 tick: update the predicted state and return the expected beat
   function automatic step_result_type advance_tick(input rk4sd_pkg::word_type force_in);
      longint f, dt, hdt, dt6, x, v;
      longint a1, x2, v2, a2, x3, v3, a3, x4, v4, a4, xf, vf;
      step_result_type r;
      f = longint'(force_in);
      x = model_pos;
      v = model_vel;
      step_sat = 1'b0;
      dt = longint'(cfg_dt);
      hdt = dt >>> 1;
      dt6 = (dt * SIXTH_Q32) >>> 32;
      a1 = accel_of(x, v, f);
      x2 = sat_word(x + fx_mul(v, hdt));
      v2 = sat_word(v + fx_mul(a1, hdt));
      a2 = accel_of(x2, v2, f);
      x3 = sat_word(x + fx_mul(v2, hdt));
      v3 = sat_word(v + fx_mul(a2, hdt));
      a3 = accel_of(x3, v3, f);
      x4 = sat_word(x + fx_mul(v3, dt));
      v4 = sat_word(v + fx_mul(a3, dt));
      a4 = accel_of(x4, v4, f);
      xf = sat_word(x + fx_mul(dt6, slope_sum(v, v2, v3, v4)));
      vf = sat_word(v + fx_mul(dt6, slope_sum(a1, a2, a3, a4)));
      model_pos = xf;
      model_vel = vf;
      r.position = xf[rk4sd_pkg::DATA_W-1:0];
      r.velocity = vf[rk4sd_pkg::DATA_W-1:0];
      r.overflow = step_sat;
      return r;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic queue_force(input rk4sd_pkg::word_type f);
      force_q.insert(force_q.size(), f);
      forces_queued++;
   endtask

   // register write at a falling edge, mirrored into the predictor
   task automatic write_csr(input logic [rk4sd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rk4sd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         rk4sd_pkg::CSR_TIME_STEP: cfg_dt = data[rk4sd_pkg::DT_W-1:0];
         rk4sd_pkg::CSR_SPRING: cfg_k = data[rk4sd_pkg::COEF_W-1:0];
         rk4sd_pkg::CSR_DAMPING: cfg_c = data[rk4sd_pkg::COEF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [rk4sd_pkg::DT_W-1:0] dt,
                                input logic [rk4sd_pkg::COEF_W-1:0] k,
                                input logic [rk4sd_pkg::COEF_W-1:0] c, input bit stray);
      write_csr(rk4sd_pkg::CSR_TIME_STEP, rk4sd_pkg::CSR_DATA_W'(dt));
      write_csr(rk4sd_pkg::CSR_SPRING, k);
      write_csr(rk4sd_pkg::CSR_DAMPING, c);
      // a write to the unused index must not disturb anything
      if (stray) begin
         write_csr(CSR_UNUSED, rk4sd_pkg::CSR_DATA_W'($urandom));
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // wait until every queued force has come back as a checked beat
   task automatic wait_drained();
      int spins;
      spins = 0;
      while ((forces_taken != forces_queued || next_state_q.size() != 0) && spins < 20000) begin
         @(negedge clock);
         spins++;
      end
      repeat (3) @(negedge clock);
   endtask

   function automatic int idle_odds();
      case ($urandom_range(3))
         0: return 0;
         1: return 10;
         2: return 25;
         default: return 50;
      endcase
   endfunction

   function automatic logic [rk4sd_pkg::COEF_W-1:0] draw_coef();
      case ($urandom_range(2))
         0: return '0;
         1: return '1;
         default: return rk4sd_pkg::COEF_W'($urandom);
      endcase
   endfunction

   // mostly moderate forces, some full-range words and corner values
   function automatic rk4sd_pkg::word_type draw_force();
      int sel;
      sel = $urandom_range(99);
      if (sel < 80) begin
         return rk4sd_pkg::word_type'($signed($urandom) >>> $urandom_range(27, 11));
      end
      if (sel < 92) begin
         return rk4sd_pkg::word_type'($urandom);
      end
      case ($urandom_range(4))
         0: return rk4sd_pkg::word_type'(WORD_MAX);
         1: return rk4sd_pkg::word_type'(WORD_MIN);
         2: return '0;
         3: return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   // request driver: holds a beat until taken, idles in short bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (force_q.size() != 0 && $urandom_range(99) < gap_pct) begin
            gap_left = $urandom_range(3);
            req_valid <= 1'b0;
         end else if (force_q.size() != 0) begin
            req_valid <= 1'b1;
            req_force_req <= force_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure in short bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = $urandom_range(3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin
      req_fired <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         next_state_q.insert(next_state_q.size(), advance_tick(req_force_req));
         forces_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (next_state_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat: pos %h vel %h ovf %b",
                                    rsp_position, rsp_velocity, rsp_overflow));
         end else begin
            predicted = next_state_q.pop_front();
            if (rsp_position !== predicted.position || rsp_velocity !== predicted.velocity ||
                rsp_overflow !== predicted.overflow) begin
               note_mismatch($sformatf(
                  "tick %0d: expected pos %h vel %h ovf %b, got pos %h vel %h ovf %b",
                  ticks_checked, predicted.position, predicted.velocity, predicted.overflow,
                  rsp_position, rsp_velocity, rsp_overflow));
            end
         end
         ticks_checked++;
      end
   end

   // stimulus
   initial begin : stimulus
      int n;
      int kind;
      logic [rk4sd_pkg::DT_W-1:0] dt;
      logic [rk4sd_pkg::COEF_W-1:0] k;
      logic [rk4sd_pkg::COEF_W-1:0] c;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 20;

      // reset defaults: small values, unit force, extremes, saturation runs
      queue_force(32'sd0);
      queue_force(32'sd1);
      queue_force(-32'sd1);
      queue_force(32'sh0001_0000);
      queue_force(-32'sh0001_0000);
      queue_force(rk4sd_pkg::word_type'(WORD_MAX));
      queue_force(rk4sd_pkg::word_type'(WORD_MIN));
      repeat (3) queue_force(rk4sd_pkg::word_type'(WORD_MAX));
      repeat (3) queue_force(rk4sd_pkg::word_type'(WORD_MIN));
      repeat (2) queue_force(32'sd0);
      wait_drained();

      // zero step leaves the state alone
      apply_setting('0, draw_coef(), draw_coef(), 1'b1);
      queue_force(32'sh0001_0000);
      queue_force(rk4sd_pkg::word_type'(WORD_MIN));
      wait_drained();

      // widest step with the largest coefficients
      apply_setting('1, '1, '1, 1'b0);
      queue_force(rk4sd_pkg::word_type'(WORD_MAX));
      queue_force(rk4sd_pkg::word_type'(WORD_MIN));
      queue_force(32'sd0);
      wait_drained();

      // smallest step, no spring, no damping
      apply_setting(17'd1, '0, '0, 1'b0);
      queue_force(rk4sd_pkg::word_type'(WORD_MAX));
      queue_force(32'sd1);
      wait_drained();

      // random phases, each with its own setting; all but the last with random idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = idle_odds();
            stall_pct = idle_odds();
         end
         if (p == 0 || $urandom_range(9) < 7) begin
            // a stable, well-behaved oscillator
            dt = rk4sd_pkg::DT_W'($urandom_range(32768, 64));
            k = rk4sd_pkg::COEF_W'($urandom_range(8 << rk4sd_pkg::FRAC_W));
            c = rk4sd_pkg::COEF_W'($urandom_range(4 << rk4sd_pkg::FRAC_W));
         end else begin
            kind = $urandom_range(4);
            case (kind)
               0: dt = 17'd1;
               1: dt = 17'd65536;
               2: dt = '1;
               3: dt = '0;
               default: dt = rk4sd_pkg::DT_W'($urandom);
            endcase
            k = draw_coef();
            c = draw_coef();
         end
         apply_setting(dt, k, c, $urandom_range(3) == 0);
         n = $urandom_range(120, 80);
         repeat (n) queue_force(draw_force());
         wait_drained();
      end

      repeat (25) @(negedge clock);
      if (mismatches == 0 && next_state_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
src/rk4sd_pkg.sv
src/rk4_spring_damper_step_top.sv
verif/rk4_spring_damper_step_top_tb.sv
